### hdl/hrid_pkg.sv
// Shared types and constants for the handle registry with id allocator.
// Used by hrid_ctrl and handle_registry_with_id_allocator; depends on nothing.
package hrid_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned ID_COUNT_DEF    = 256;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  // Fixed field widths on the stream ports.
  localparam int unsigned ID_W     = 16;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  // Wide enough to compare a 16-bit id against an id count of 65536.
  localparam int unsigned ID_CMP_W = ID_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_GET    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    status_e             status;
  } result_t;

endpackage

### hdl/handle_registry_with_id_allocator.sv
// Top level of the handle registry: stream ports, output register and assertions.
// Depends on hrid_pkg, hrid_mem and hrid_ctrl.
//
//   channel   direction  tdata (low bit up)              tuser
//   s_axis    in         handle[31:0], id_in[47:32]       cmd[1:0]
//   m_axis    out        id_out[15:0], handle_out[47:16]  status[1:0]
//
// After reset the block runs a clearing pass over all ID_COUNT entries of the
// memory, with s_axis_tready low, so that every id starts neither valid nor freed.
// Add, remove and find scan the memory in id order, one entry a cycle through its
// single read port; get reads only the entry of its id, and an id beyond the table
// needs no memory read.
// One command is worked on at a time. A finished result sits in the output
// register, and the next command is taken while it waits for m_axis_tready.
module handle_registry_with_id_allocator
  import hrid_pkg::*;
#(
  parameter int unsigned ID_COUNT    = ID_COUNT_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [HANDLE_W+ID_W-1:0]     s_axis_tdata,   // handle, id_in
  input  logic [CMD_W-1:0]             s_axis_tuser,   // cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ID_W+HANDLE_W-1:0]     m_axis_tdata,   // id_out, handle_out
  output logic [STATUS_W-1:0]          m_axis_tuser    // status
);

  localparam int unsigned AW = $clog2(ID_COUNT);
  localparam int unsigned HB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int unsigned EW = HB + 2;

  logic          res_valid, res_ready;
  result_t       res;
  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [EW-1:0] mem_wr_data, mem_rd_data;

  // Output register: a result beat waits here while the sequencer moves on.
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  hrid_ctrl #(
    .ID_COUNT    (ID_COUNT),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_o   (s_axis_tready),
    .cmd_i         (cmd_e'(s_axis_tuser)),
    .handle_i      (s_axis_tdata[HANDLE_W-1:0]),
    .id_i          (s_axis_tdata[HANDLE_W+ID_W-1:HANDLE_W]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  hrid_mem #(
    .DEPTH (ID_COUNT),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // The register can take a new result when empty or when its beat leaves now.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.handle, out_q.id};
  assign m_axis_tuser  = out_q.status;

  // A failed command reports neither an id nor a handle.
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("failed command carries a nonzero id or handle");

  // Only get returns a handle, and get never returns an id.
  a_id_or_handle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.id != '0)) |-> (out_q.handle == '0))
    else $error("result carries both an id and a handle");

  // The sequencer only takes a command once its previous result has been handed on.
  a_ready_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid)
    else $error("command accepted while a result is pending in the sequencer");

endmodule

### hdl/hrid_mem.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
// Holds one entry per id; no dependencies.
module hrid_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 34,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/hrid_ctrl.sv
// Command sequencer: clearing pass, table scans, read-modify-write of entries.
// Depends on hrid_pkg; drives one hrid_mem instance held in the top level.
module hrid_ctrl
  import hrid_pkg::*;
#(
  parameter int unsigned ID_COUNT    = ID_COUNT_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned AW = $clog2(ID_COUNT),
  localparam int unsigned HB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W,
  localparam int unsigned EW = HB + 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_e                cmd_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [ID_W-1:0]     id_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output result_t             res_o,
  output logic                mem_wr_en_o,
  output logic [AW-1:0]       mem_wr_addr_o,
  output logic [EW-1:0]       mem_wr_data_o,
  output logic                mem_rd_en_o,
  output logic [AW-1:0]       mem_rd_addr_o,
  input  logic [EW-1:0]       mem_rd_data_i
);

  // Entry layout: {valid, freed, handle}.
  localparam logic [AW-1:0] LAST_ID = AW'(ID_COUNT - 1);
  localparam logic [AW:0]   FRESH_END = (AW+1)'(ID_COUNT);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_GET   = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [HB-1:0]   handle_q, handle_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [AW:0]     fresh_q, fresh_d;
  result_t         res_q, res_d;

  logic            ent_valid, ent_freed, hit;
  logic [HB-1:0]   ent_handle;

  assign ent_valid  = mem_rd_data_i[HB+1];
  assign ent_freed  = mem_rd_data_i[HB];
  assign ent_handle = mem_rd_data_i[HB-1:0];
  assign hit = (cmd_q == CMD_ADD) ? ent_freed : (ent_valid && (ent_handle == handle_q));

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    handle_d      = handle_q;
    addr_d        = addr_q;
    fresh_d       = fresh_q;
    res_d         = res_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = addr_q;
    mem_wr_data_o = '0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = addr_q + AW'(1);

    unique case (state_q)
      S_CLEAR: begin
        mem_wr_en_o = 1'b1;
        if (addr_q == LAST_ID) begin
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          handle_d = handle_i[HB-1:0];
          if (cmd_i == CMD_GET) begin
            if (ID_CMP_W'(id_i) >= ID_CMP_W'(ID_COUNT)) begin
              res_d   = '{id: '0, handle: '0, status: ST_NOT_FOUND};
              state_d = S_RESP;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = id_i[AW-1:0];
              state_d       = S_GET;
            end
          end else begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = '0;
            addr_d        = '0;
            state_d       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // addr_q is the id whose entry is on the read port this cycle.
        if (hit) begin
          res_d   = '{id: ID_W'(addr_q), handle: '0, status: ST_OK};
          state_d = S_RESP;
          if (cmd_q == CMD_ADD) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_data_o = {1'b1, 1'b0, handle_q};
          end else if (cmd_q == CMD_REMOVE) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_data_o = {1'b0, 1'b1, ent_handle};
          end
        end else if (addr_q == LAST_ID) begin
          state_d = S_RESP;
          if (cmd_q != CMD_ADD) begin
            res_d = '{id: '0, handle: '0, status: ST_NOT_FOUND};
          end else if (fresh_q == FRESH_END) begin
            res_d = '{id: '0, handle: '0, status: ST_EXHAUSTED};
          end else begin
            mem_wr_en_o   = 1'b1;
            mem_wr_addr_o = fresh_q[AW-1:0];
            mem_wr_data_o = {1'b1, 1'b0, handle_q};
            res_d         = '{id: ID_W'(fresh_q[AW-1:0]), handle: '0, status: ST_OK};
            fresh_d       = fresh_q + (AW+1)'(1);
          end
        end else begin
          mem_rd_en_o = 1'b1;
          addr_d      = addr_q + AW'(1);
        end
      end
      S_GET: begin
        res_d   = '{id: '0,
                    handle: ent_valid ? HANDLE_W'(ent_handle) : '0,
                    status: ST_OK};
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      fresh_q <= (AW+1)'(1);
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    handle_q <= handle_d;
    res_q    <= res_d;
  end

endmodule
